@@ rtl/touch_sample_filter_and_map_assert.svh @@
// Assertion macros for the touch sample filter and map block.
// Included by the top level; needs nothing else.
`ifndef TOUCH_SAMPLE_FILTER_AND_MAP_ASSERT_SVH
`define TOUCH_SAMPLE_FILTER_AND_MAP_ASSERT_SVH
`ifndef SYNTHESIS
// Checks that a condition holds at every clock edge outside reset.
`define TSFM_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("touch filter: invariant violated");
// Checks that a trigger is followed by a condition in the next cycle.
`define TSFM_ASSERT_NEXT(label, clk, rst, trig, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) \
    else $error("touch filter: sequence violated");
`else
`define TSFM_ASSERT_ALWAYS(label, clk, rst, expr)
`define TSFM_ASSERT_NEXT(label, clk, rst, trig, expr)
`endif
`endif

@@ rtl/tsfm_pkg.sv @@
// Shared types and constants for the touch sample filter and map block.
// No dependencies.
`timescale 1ns / 1ps
package tsfm_pkg;

  localparam int FRAME_LEN  = 9;
  localparam int GROUP_LEN  = 3;
  localparam int NUM_GROUPS = 3;
  localparam int COUNT_W    = 4;
  localparam int GROUP_W    = 2;

  localparam int COEF_W  = 32;
  localparam int LIMIT_W = 12;
  localparam int POS_W   = 16;

  localparam logic [POS_W-1:0]   PEN_UP_POS         = 16'hFFFF;
  localparam logic [POS_W-1:0]   POS_MAX            = 16'hFFFF;
  localparam logic [LIMIT_W-1:0] SPREAD_LIMIT_RESET = 12'd10;

  // floor(n / 3) = (n * RECIP3) >> DIV3_SHIFT for every n below 2^19.
  localparam int                  RECIP3_W   = 18;
  localparam logic [RECIP3_W-1:0] RECIP3     = 18'h2AAAB;
  localparam int                  DIV3_SHIFT = 19;

  localparam int RESULT_DEPTH   = 8;
  localparam int RESULT_PTR_W   = 3;
  localparam int RESULT_LEVEL_W = 4;

  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_X_FROM_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_X_FROM_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_Y_FROM_X = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_Y_FROM_Y = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPREAD_LIMIT  = 3'd6;

  typedef struct packed {
    logic [COEF_W-1:0] cx;
    logic [COEF_W-1:0] cy;
    logic [COEF_W-1:0] off;
  } axis_coef_t;

  typedef struct packed {
    logic valid;
    logic pen;
  } frame_tag_t;

  typedef struct packed {
    logic valid;
    logic touched;
    logic frame_ok;
  } map_tag_t;

  typedef struct packed {
    logic             touched;
    logic             frame_ok;
    logic [POS_W-1:0] screen_x;
    logic [POS_W-1:0] screen_y;
  } result_t;

endpackage

@@ rtl/touch_sample_filter_and_map.sv @@
// Throughput: one input transfer per cycle, set by the credit counter of the
// eight-entry result queue; input ready falls while eight results are outstanding.
// Reset (rst, synchronous, active high) clears the sample count, the filtered
// position, the coefficients (to zero), the spread limit (to ten) and the queue.
`timescale 1ns / 1ps
`include "touch_sample_filter_and_map_assert.svh"

// The block collects nine x/y sample pairs into a frame of three groups,
// filters each axis by a spread check on the rounded group means and then
// maps the filtered position to screen coordinates with an affine transform.
// A pen-released transfer produces a fixed report and restarts the frame.
//
// Pipeline after an input transfer that produces a result:
//   stage 1  frame snapshot of the six group sums and the item tag
//   stage 2  rounded group means (tsfm_filter, both axes)
//   stage 3  spread check and closest-pair average (tsfm_filter)
//   stage 4  update of the held filtered position
//   stage 5  four coefficient products (tsfm_map)
//   stage 6  sums with the offsets, then saturation into the queue
module touch_sample_filter_and_map #(
  parameter int SAMPLE_BITS    = 12,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // Input stream.
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata, from bit 0: x_sample, y_sample, zero padding to whole bytes.
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // tuser: op (0 sample pair, 1 pen released).
  input  logic                                    s_axis_tuser,
  // Result stream.
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // tdata, from bit 0: screen_x, screen_y.
  output logic [2*tsfm_pkg::POS_W-1:0]            m_axis_tdata,
  // tuser, from bit 0: touched, frame_ok.
  output logic [1:0]                              m_axis_tuser,
  // Configuration write channel.
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [tsfm_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [tsfm_pkg::COEF_W-1:0]             cfg_data
);

  localparam int SUM_W = SAMPLE_BITS + 2;

  // Configuration registers.
  tsfm_pkg::axis_coef_t               coef_x, coef_y;
  logic [tsfm_pkg::LIMIT_W-1:0]       spread_limit;

  // Frame collection state.
  logic [tsfm_pkg::COUNT_W-1:0]       sample_count;
  logic [SUM_W-1:0]                   gsum_x [tsfm_pkg::NUM_GROUPS];
  logic [SUM_W-1:0]                   gsum_y [tsfm_pkg::NUM_GROUPS];
  logic [SAMPLE_BITS-1:0]             filtered_x, filtered_y;

  // Pipeline.
  tsfm_pkg::frame_tag_t               s1_tag, s2_tag, s3_tag;
  tsfm_pkg::map_tag_t                 map_tag;
  logic [tsfm_pkg::NUM_GROUPS-1:0][SUM_W-1:0] s1_sum_x, s1_sum_y;
  logic                               ok_x, ok_y;
  logic [SAMPLE_BITS-1:0]             held_x, held_y;

  // Output side.
  logic                               push;
  tsfm_pkg::result_t                  push_data, out_data;
  logic [tsfm_pkg::RESULT_LEVEL_W-1:0] fifo_level;
  logic [tsfm_pkg::RESULT_LEVEL_W-1:0] outstanding;

  // Input decode.
  logic                               accept, pen_in, frame_end, group_start, has_result;
  logic                               pop;
  logic [tsfm_pkg::GROUP_W-1:0]       group_idx;
  logic [SAMPLE_BITS-1:0]             xs, ys;
  logic [SUM_W-1:0]                   new_sum_x, new_sum_y;

  assign xs     = s_axis_tdata[SAMPLE_BITS-1:0];
  assign ys     = s_axis_tdata[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
  assign pen_in = s_axis_tuser;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign pop    = m_axis_tvalid && m_axis_tready;

  // Input is held off only by the credit for the result queue, so every
  // result that enters the pipeline is sure of a slot when it leaves it.
  assign s_axis_tready = (outstanding < tsfm_pkg::RESULT_LEVEL_W'(tsfm_pkg::RESULT_DEPTH));
  assign cfg_ready     = 1'b1;

  always_comb begin
    frame_end   = (sample_count == tsfm_pkg::COUNT_W'(tsfm_pkg::FRAME_LEN - 1));
    group_start = sample_count inside {tsfm_pkg::COUNT_W'(0),
                                       tsfm_pkg::COUNT_W'(tsfm_pkg::GROUP_LEN),
                                       tsfm_pkg::COUNT_W'(2 * tsfm_pkg::GROUP_LEN)};
    if (sample_count >= tsfm_pkg::COUNT_W'(2 * tsfm_pkg::GROUP_LEN)) begin
      group_idx = tsfm_pkg::GROUP_W'(2);
    end else if (sample_count >= tsfm_pkg::COUNT_W'(tsfm_pkg::GROUP_LEN)) begin
      group_idx = tsfm_pkg::GROUP_W'(1);
    end else begin
      group_idx = tsfm_pkg::GROUP_W'(0);
    end
    // The opening sample of a group overwrites its sum, so a stale sum from
    // an abandoned frame is never read.
    new_sum_x  = group_start ? SUM_W'(xs) : gsum_x[group_idx] + SUM_W'(xs);
    new_sum_y  = group_start ? SUM_W'(ys) : gsum_y[group_idx] + SUM_W'(ys);
    has_result = pen_in || frame_end;
  end

  // Control state, configuration and the held filtered position.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      s1_tag       <= '0;
      s2_tag       <= '0;
      s3_tag       <= '0;
      map_tag      <= '0;
      filtered_x   <= '0;
      filtered_y   <= '0;
      coef_x       <= '0;
      coef_y       <= '0;
      spread_limit <= tsfm_pkg::SPREAD_LIMIT_RESET;
      outstanding  <= '0;
    end else begin
      if (accept) begin
        if (pen_in || frame_end) begin
          sample_count <= '0;
        end else begin
          sample_count <= sample_count + 1'b1;
        end
      end

      s1_tag.valid <= accept && has_result;
      s1_tag.pen   <= pen_in;
      s2_tag       <= s1_tag;
      s3_tag       <= s2_tag;

      // A frame passes only when both axes pass; a rejected frame keeps the
      // previous position and is still mapped and reported.
      map_tag.valid    <= s3_tag.valid;
      map_tag.touched  <= !s3_tag.pen;
      map_tag.frame_ok <= s3_tag.valid && !s3_tag.pen && ok_x && ok_y;
      if (s3_tag.valid && !s3_tag.pen && ok_x && ok_y) begin
        filtered_x <= held_x;
        filtered_y <= held_y;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tsfm_pkg::REG_COEF_X_FROM_X: coef_x.cx    <= cfg_data;
          tsfm_pkg::REG_COEF_X_FROM_Y: coef_x.cy    <= cfg_data;
          tsfm_pkg::REG_OFFSET_X:      coef_x.off   <= cfg_data;
          tsfm_pkg::REG_COEF_Y_FROM_X: coef_y.cx    <= cfg_data;
          tsfm_pkg::REG_COEF_Y_FROM_Y: coef_y.cy    <= cfg_data;
          tsfm_pkg::REG_OFFSET_Y:      coef_y.off   <= cfg_data;
          tsfm_pkg::REG_SPREAD_LIMIT:  spread_limit <= cfg_data[tsfm_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end

      outstanding <= outstanding
                   + tsfm_pkg::RESULT_LEVEL_W'(accept && has_result)
                   - tsfm_pkg::RESULT_LEVEL_W'(pop);
    end
  end

  // Group sums and the frame snapshot carry no reset.
  always_ff @(posedge clk) begin
    if (accept && !pen_in) begin
      gsum_x[group_idx] <= new_sum_x;
      gsum_y[group_idx] <= new_sum_y;
      if (frame_end) begin
        s1_sum_x <= {new_sum_x, gsum_x[1], gsum_x[0]};
        s1_sum_y <= {new_sum_y, gsum_y[1], gsum_y[0]};
      end
    end
  end

  tsfm_filter #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_filter_x (
    .clk   (clk),
    .sums  (s1_sum_x),
    .limit (spread_limit),
    .ok    (ok_x),
    .held  (held_x)
  );

  tsfm_filter #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_filter_y (
    .clk   (clk),
    .sums  (s1_sum_y),
    .limit (spread_limit),
    .ok    (ok_y),
    .held  (held_y)
  );

  tsfm_map #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_map (
    .clk    (clk),
    .rst    (rst),
    .tag_in (map_tag),
    .fx     (filtered_x),
    .fy     (filtered_y),
    .coef_x (coef_x),
    .coef_y (coef_y),
    .push   (push),
    .result (push_data)
  );

  tsfm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_data  (out_data),
    .level     (fifo_level)
  );

  assign m_axis_tdata = {out_data.screen_y, out_data.screen_x};
  assign m_axis_tuser = {out_data.frame_ok, out_data.touched};

  // The credit counter never promises more than the queue holds.
  `TSFM_ASSERT_ALWAYS(a_credit_bound, clk, rst, outstanding <= tsfm_pkg::RESULT_LEVEL_W'(tsfm_pkg::RESULT_DEPTH))
  // Every queued result is covered by a credit.
  `TSFM_ASSERT_ALWAYS(a_queue_covered, clk, rst, fifo_level <= outstanding)
  // The sample count stays inside one frame.
  `TSFM_ASSERT_ALWAYS(a_count_range, clk, rst, sample_count < tsfm_pkg::COUNT_W'(tsfm_pkg::FRAME_LEN))
  // A pen-released transfer enters the pipeline in the following cycle.
  `TSFM_ASSERT_NEXT(a_pen_enters, clk, rst, accept && pen_in, s1_tag.valid && s1_tag.pen)

endmodule

@@ rtl/tsfm_filter.sv @@
// One axis of the frame filter: group means, spread check and pair average.
// Depends on tsfm_pkg.
`timescale 1ns / 1ps
module tsfm_filter #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                                clk,
  input  logic [tsfm_pkg::NUM_GROUPS-1:0][SAMPLE_BITS+1:0]    sums,
  input  logic [tsfm_pkg::LIMIT_W-1:0]                        limit,
  output logic                                                ok,
  output logic [SAMPLE_BITS-1:0]                              held
);

  localparam int SUM_W  = SAMPLE_BITS + 2;
  localparam int N_W    = SUM_W + 1;
  localparam int PROD_W = N_W + tsfm_pkg::RECIP3_W;
  localparam int CMP_W  = (SAMPLE_BITS > tsfm_pkg::LIMIT_W) ? SAMPLE_BITS : tsfm_pkg::LIMIT_W;

  logic [PROD_W-1:0] prod [tsfm_pkg::NUM_GROUPS];
  logic [tsfm_pkg::NUM_GROUPS-1:0][SAMPLE_BITS-1:0] mean;
  logic [SAMPLE_BITS-1:0] d0, d1, d2;
  logic                   ok_next;
  logic [SAMPLE_BITS-1:0] held_next;

  function automatic logic [SAMPLE_BITS-1:0] absdiff(input logic [SAMPLE_BITS-1:0] a,
                                                     input logic [SAMPLE_BITS-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] avg(input logic [SAMPLE_BITS-1:0] a,
                                                 input logic [SAMPLE_BITS-1:0] b);
    logic [SAMPLE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SAMPLE_BITS:1];
  endfunction

  // Rounded group mean, floor((sum + 1) / 3), by reciprocal multiplication.
  always_comb begin
    for (int i = 0; i < tsfm_pkg::NUM_GROUPS; i++) begin
      prod[i] = PROD_W'(N_W'(sums[i]) + N_W'(1)) * PROD_W'(tsfm_pkg::RECIP3);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < tsfm_pkg::NUM_GROUPS; i++) begin
      mean[i] <= prod[i][tsfm_pkg::DIV3_SHIFT +: SAMPLE_BITS];
    end
  end

  // Circular neighbour differences, then the closest pair is averaged.
  always_comb begin
    d0 = absdiff(mean[0], mean[1]);
    d1 = absdiff(mean[1], mean[2]);
    d2 = absdiff(mean[2], mean[0]);
    ok_next = (CMP_W'(d0) <= CMP_W'(limit)) && (CMP_W'(d1) <= CMP_W'(limit)) &&
              (CMP_W'(d2) <= CMP_W'(limit));
    if (d0 < d1) begin
      held_next = (d2 < d0) ? avg(mean[0], mean[2]) : avg(mean[0], mean[1]);
    end else if (d2 < d1) begin
      held_next = avg(mean[0], mean[2]);
    end else begin
      held_next = avg(mean[1], mean[2]);
    end
  end

  always_ff @(posedge clk) begin
    ok   <= ok_next;
    held <= held_next;
  end

endmodule

@@ rtl/tsfm_map.sv @@
// Affine screen mapping of the filtered position, with saturation.
// Depends on tsfm_pkg.
`timescale 1ns / 1ps
module tsfm_map #(
  parameter int SAMPLE_BITS    = 12,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  tsfm_pkg::map_tag_t     tag_in,
  input  logic [SAMPLE_BITS-1:0] fx,
  input  logic [SAMPLE_BITS-1:0] fy,
  input  tsfm_pkg::axis_coef_t   coef_x,
  input  tsfm_pkg::axis_coef_t   coef_y,
  output logic                   push,
  output tsfm_pkg::result_t      result
);

  localparam int PROD_W = tsfm_pkg::COEF_W + SAMPLE_BITS + 1;
  localparam int ACC_W  = PROD_W + 2;

  tsfm_pkg::map_tag_t p_tag, a_tag;
  logic signed [SAMPLE_BITS:0] fx_s, fy_s;
  logic signed [PROD_W-1:0]    p_xx, p_xy, p_yx, p_yy;
  logic signed [PROD_W-1:0]    p_offx, p_offy;
  logic signed [ACC_W-1:0]     acc_x, acc_y;

  // Truncation toward zero and clamping to the screen range: a negative sum
  // can only give zero, so only its sign matters.
  function automatic logic [tsfm_pkg::POS_W-1:0] saturate(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-1:0] q;
    q = $unsigned(a) >> COEF_FRAC_BITS;
    if (a < 0) begin
      return '0;
    end else if (q > ACC_W'(tsfm_pkg::POS_MAX)) begin
      return tsfm_pkg::POS_MAX;
    end else begin
      return q[tsfm_pkg::POS_W-1:0];
    end
  endfunction

  assign fx_s = $signed({1'b0, fx});
  assign fy_s = $signed({1'b0, fy});

  always_ff @(posedge clk) begin
    if (rst) begin
      p_tag <= '0;
      a_tag <= '0;
    end else begin
      p_tag <= tag_in;
      a_tag <= p_tag;
    end
  end

  always_ff @(posedge clk) begin
    p_xx   <= PROD_W'($signed(coef_x.cx)) * PROD_W'(fx_s);
    p_xy   <= PROD_W'($signed(coef_x.cy)) * PROD_W'(fy_s);
    p_yx   <= PROD_W'($signed(coef_y.cx)) * PROD_W'(fx_s);
    p_yy   <= PROD_W'($signed(coef_y.cy)) * PROD_W'(fy_s);
    p_offx <= PROD_W'($signed(coef_x.off));
    p_offy <= PROD_W'($signed(coef_y.off));
    acc_x  <= ACC_W'(p_xx) + ACC_W'(p_xy) + ACC_W'(p_offx);
    acc_y  <= ACC_W'(p_yx) + ACC_W'(p_yy) + ACC_W'(p_offy);
  end

  always_comb begin
    push            = a_tag.valid;
    result.touched  = a_tag.touched;
    result.frame_ok = a_tag.frame_ok;
    result.screen_x = a_tag.touched ? saturate(acc_x) : tsfm_pkg::PEN_UP_POS;
    result.screen_y = a_tag.touched ? saturate(acc_y) : tsfm_pkg::PEN_UP_POS;
  end

endmodule

@@ rtl/tsfm_fifo.sv @@
// Result queue in flip-flops between the mapping pipeline and the output.
// Depends on tsfm_pkg.
`timescale 1ns / 1ps
module tsfm_fifo (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  input  tsfm_pkg::result_t                     push_data,
  input  logic                                  pop,
  output logic                                  out_valid,
  output tsfm_pkg::result_t                     out_data,
  output logic [tsfm_pkg::RESULT_LEVEL_W-1:0]   level
);

  tsfm_pkg::result_t slot [tsfm_pkg::RESULT_DEPTH];
  logic [tsfm_pkg::RESULT_PTR_W-1:0] wr_ptr, rd_ptr;
  logic do_pop;

  assign out_valid = (level != '0);
  assign out_data  = slot[rd_ptr];
  assign do_pop    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + tsfm_pkg::RESULT_LEVEL_W'(push)
                     - tsfm_pkg::RESULT_LEVEL_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule
